FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file, spo_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low synchronous reset
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under an active-low synchronous reset
`define ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/spo_pkg.sv
// Shared types, codes and constants of the smoothed pulse oscillator.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package spo_pkg;

    // Default build parameters
    localparam int DEF_TABLE_SIZE      = 512;
    localparam int DEF_PHASE_FRAC_BITS = 23;

    // Edge shaping arithmetic
    localparam int DIV_STEPS = 15;                       // 30 fraction bits, 2 per cycle
    localparam logic signed [31:0] TWO_THIRDS_Q30 = 32'sd715827883;
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;      // ceil(2^33 / 3)

    // Register reset values
    localparam logic [31:0] RST_PHASE_STEP_SCALE = 32'd2863312;
    localparam logic [16:0] RST_PULSE_WIDTH      = 17'd65536;
    localparam logic [23:0] RST_BANDWIDTH        = 24'd2560000;
    localparam logic [31:0] RST_SLEW_SCALE       = 32'd429497;
    localparam int          RST_HELD_WIDTH       = 65536;

    // Register indexes
    localparam logic [1:0] CFG_PHASE_STEP_SCALE = 2'd0;
    localparam logic [1:0] CFG_PULSE_WIDTH      = 2'd1;
    localparam logic [1:0] CFG_BANDWIDTH        = 2'd2;
    localparam logic [1:0] CFG_SLEW_SCALE       = 2'd3;

    // Waveform regions
    localparam logic [1:0] RG_RISE = 2'd0;
    localparam logic [1:0] RG_HIGH = 2'd1;
    localparam logic [1:0] RG_FALL = 2'd2;
    localparam logic [1:0] RG_LOW  = 2'd3;

    // Datapath operations
    localparam logic [3:0] OP_NOP    = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_MUL_S  = 4'd2;
    localparam logic [3:0] OP_MUL_P  = 4'd3;
    localparam logic [3:0] OP_SETUP  = 4'd4;
    localparam logic [3:0] OP_DIV    = 4'd5;
    localparam logic [3:0] OP_SQ     = 4'd6;
    localparam logic [3:0] OP_CUBE   = 4'd7;
    localparam logic [3:0] OP_THIRD  = 4'd8;
    localparam logic [3:0] OP_FIN    = 4'd9;
    localparam logic [3:0] OP_DIFF   = 4'd10;
    localparam logic [3:0] OP_INTERP = 4'd11;
    localparam logic [3:0] OP_ROUND  = 4'd12;

    typedef struct packed {
        logic [3:0] op;
        logic       pt;   // 0: point at the phase index, 1: the point after it
    } spo_cmd_t;

    typedef struct packed {
        logic konst;      // point evaluates to a flat level, no division
    } spo_stat_t;

endpackage

FILE: rtl/core/smoothed_pulse_oscillator.sv
// Smoothed pulse oscillator: one frequency word in, one pulse-wave sample word out.
// Input channel s_*: s_freq (signed Q16.8 Hz), s_sync, s_sync_phase; valid/ready.
// Output channel m_*: m_sample (signed Q1.15), valid/ready, held in an output
// register so the next word can be taken while a sample waits.
// Configuration: cfg_we/cfg_index/cfg_data; the user must see that it is written only
// while the block is idle, as the block itself does not enforce this. A word is loaded
// and scaled, then each of its two table points is set up; an edge point adds a pass of
// the two-bit-per-cycle divider and the square, cube and one-third steps on the shared
// multiplier. One word is in flight at a time: s_ready returns together with m_valid
// once the sample is registered, so a new word is taken only after the last is finished.
// Reset (aresetn low, synchronous) restores the register defaults, clears the
// phase, reloads the held pulse width and empties the output register.
// A stalled receiver holds m_sample; a finished word waits in the last step
// until the output register is free, and s_ready stays low meanwhile.
`timescale 1ns / 1ps
module smoothed_pulse_oscillator #(
    parameter int TABLE_SIZE      = spo_pkg::DEF_TABLE_SIZE,
    parameter int PHASE_FRAC_BITS = spo_pkg::DEF_PHASE_FRAC_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [23:0] s_freq,
    input  logic               s_sync,
    input  logic [31:0]        s_sync_phase,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_sample
);
    import spo_pkg::*;

    spo_cmd_t  cmd;
    spo_stat_t stat;

    // Sequencer
    spo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Arithmetic and state
    spo_datapath #(
        .TABLE_SIZE      (TABLE_SIZE),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_freq       (s_freq),
        .s_sync       (s_sync),
        .s_sync_phase (s_sync_phase),
        .cmd          (cmd),
        .stat         (stat),
        .m_sample     (m_sample)
    );

endmodule

FILE: rtl/core/spo_ctrl.sv
// Sequencer of the smoothed pulse oscillator: walks the datapath through one word.
// Depends on spo_pkg for operation codes and the command and status types.
`timescale 1ns / 1ps
module spo_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  spo_pkg::spo_stat_t stat,
    output spo_pkg::spo_cmd_t  cmd
);
    import spo_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MUL_S  = 4'd1;
    localparam logic [3:0] ST_MUL_P  = 4'd2;
    localparam logic [3:0] ST_SETUP  = 4'd3;
    localparam logic [3:0] ST_DIV    = 4'd4;
    localparam logic [3:0] ST_SQ     = 4'd5;
    localparam logic [3:0] ST_CUBE   = 4'd6;
    localparam logic [3:0] ST_THIRD  = 4'd7;
    localparam logic [3:0] ST_FIN    = 4'd8;
    localparam logic [3:0] ST_DIFF   = 4'd9;
    localparam logic [3:0] ST_INTERP = 4'd10;
    localparam logic [3:0] ST_ROUND  = 4'd11;

    logic [3:0]       state_reg, state_next;
    logic             pt_reg, pt_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             mv_reg, mv_next;

    // Sequence the operations of one word
    always_comb begin
        state_next = state_reg;
        pt_next    = pt_reg;
        cnt_next   = cnt_reg;
        mv_next    = mv_reg && !m_ready;
        cmd.op     = OP_NOP;
        cmd.pt     = pt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    pt_next    = 1'b0;
                    state_next = ST_MUL_S;
                end
            end
            ST_MUL_S: begin
                cmd.op     = OP_MUL_S;
                state_next = ST_MUL_P;
            end
            ST_MUL_P: begin
                cmd.op     = OP_MUL_P;
                state_next = ST_SETUP;
            end
            ST_SETUP: begin
                cmd.op = OP_SETUP;
                if (!stat.konst) begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else if (pt_reg) begin
                    state_next = ST_DIFF;
                end else begin
                    pt_next = 1'b1;
                end
            end
            ST_DIV: begin
                cmd.op = OP_DIV;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_SQ;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SQ: begin
                cmd.op     = OP_SQ;
                state_next = ST_CUBE;
            end
            ST_CUBE: begin
                cmd.op     = OP_CUBE;
                state_next = ST_THIRD;
            end
            ST_THIRD: begin
                cmd.op     = OP_THIRD;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.op = OP_FIN;
                if (pt_reg) begin
                    state_next = ST_DIFF;
                end else begin
                    pt_next    = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_DIFF: begin
                cmd.op     = OP_DIFF;
                state_next = ST_INTERP;
            end
            ST_INTERP: begin
                cmd.op     = OP_INTERP;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                // hold until the output register is free
                if (!mv_reg || m_ready) begin
                    cmd.op     = OP_ROUND;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pt_reg    <= 1'b0;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            pt_reg    <= pt_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;

endmodule

FILE: rtl/core/spo_datapath.sv
// Datapath of the smoothed pulse oscillator: registers, shared multiplier, divider.
// Depends on spo_pkg; driven by spo_ctrl through spo_cmd_t.
`timescale 1ns / 1ps
module spo_datapath #(
    parameter int TABLE_SIZE      = spo_pkg::DEF_TABLE_SIZE,
    parameter int PHASE_FRAC_BITS = spo_pkg::DEF_PHASE_FRAC_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic signed [23:0] s_freq,
    input  logic               s_sync,
    input  logic [31:0]        s_sync_phase,
    input  spo_pkg::spo_cmd_t  cmd,
    output spo_pkg::spo_stat_t stat,
    output logic signed [15:0] m_sample
);
    import spo_pkg::*;

    localparam int TBITS = $clog2(TABLE_SIZE);
    localparam int PW    = TBITS + PHASE_FRAC_BITS;
    localparam int CW    = (TBITS + 10 > 18) ? TBITS + 10 : 18;
    localparam int SW    = (PW > 32) ? PW : 32;
    localparam int TQ8   = TABLE_SIZE * 256;
    localparam logic [CW-1:0] TQ8_C = CW'(TQ8);

    // configuration and state
    logic [31:0]    pss_reg, ss_reg;
    logic [16:0]    pw_reg;
    logic [23:0]    bw_reg;
    logic [PW-1:0]  phase_reg, step_reg;
    logic [CW-1:0]  held_reg, s_reg, rem_reg;
    logic           done_reg, neg_reg, dneg_reg;
    logic [23:0]    f_reg;
    logic [30:0]    quo_reg, sq_reg, cube_reg, third_reg;
    logic signed [31:0] f1_reg, f2_reg, v_reg;
    logic [31:0]    dmag_reg;
    logic [15:0]    sample_reg;

    logic [23:0]    f_abs;
    logic [SW-1:0]  sp_ext;
    logic [TBITS-1:0] idx;
    logic [PHASE_FRAC_BITS-1:0] frac;
    logic [CW-1:0]  p0, p1, p_sel, sh_sum, a2, b2, mag, held_latch;
    logic [1:0]     rg;
    logic           neg_c, ge0;
    logic signed [31:0] kval;
    logic [CW:0]    t1, t2, r1, r2, s_ext;
    logic           g1, g2;
    logic [31:0]    mul_a, mul_b;
    logic [63:0]    prod;
    logic [30:0]    y, q;
    logic signed [31:0] yval, v;
    logic signed [32:0] diff, rv;

    // Fold the frequency and pick the table points
    assign f_abs  = s_freq[23] ? (~s_freq + 24'd1) : s_freq;
    assign sp_ext = SW'(s_sync_phase);
    assign idx    = phase_reg[PW-1:PHASE_FRAC_BITS];
    assign frac   = phase_reg[PHASE_FRAC_BITS-1:0];
    assign p0     = CW'({idx, 8'h00});
    assign p1     = CW'({({1'b0, idx} + 1'b1), 8'h00});
    assign p_sel  = cmd.pt ? p1 : p0;
    assign sh_sum = s_reg + held_reg;
    assign a2     = p_sel << 1;
    assign b2     = (p_sel - held_reg) << 1;

    // Classify the point and set up the edge division
    always_comb begin
        if (p_sel <= s_reg) begin
            rg = RG_RISE;
        end else if (p_sel < held_reg) begin
            rg = RG_HIGH;
        end else if (p_sel <= sh_sum) begin
            rg = RG_FALL;
        end else begin
            rg = RG_LOW;
        end
        stat.konst = 1'b1;
        kval       = TWO_THIRDS_Q30;
        mag        = '0;
        neg_c      = 1'b0;
        case (rg)
            RG_RISE: begin
                if (s_reg != '0) begin
                    stat.konst = 1'b0;
                    if (a2 >= s_reg) begin
                        mag = a2 - s_reg;
                    end else begin
                        mag   = s_reg - a2;
                        neg_c = 1'b1;
                    end
                end
            end
            RG_HIGH: begin
                kval = TWO_THIRDS_Q30;
            end
            RG_FALL: begin
                kval = -TWO_THIRDS_Q30;
                if (s_reg != '0) begin
                    stat.konst = 1'b0;
                    if (s_reg >= b2) begin
                        mag = s_reg - b2;
                    end else begin
                        mag   = b2 - s_reg;
                        neg_c = 1'b1;
                    end
                end
            end
            default: begin
                kval = -TWO_THIRDS_Q30;
            end
        endcase
    end
    assign ge0 = (mag >= s_reg);

    // Clamp the requested pulse width to [s, table length - s], s being the edge width
    always_comb begin
        if (CW'(pw_reg) < s_reg) begin
            held_latch = s_reg;
        end else if (CW'(pw_reg) > TQ8_C - s_reg) begin
            held_latch = TQ8_C - s_reg;
        end else begin
            held_latch = CW'(pw_reg);
        end
    end

    // Two restoring division steps a cycle
    assign s_ext = {1'b0, s_reg};
    assign t1    = {rem_reg, 1'b0};
    assign g1    = (t1 >= s_ext);
    assign r1    = g1 ? t1 - s_ext : t1;
    assign t2    = {r1[CW-1:0], 1'b0};
    assign g2    = (t2 >= s_ext);
    assign r2    = g2 ? t2 - s_ext : t2;

    // Shared multiplier
    always_comb begin
        case (cmd.op)
            OP_MUL_S: begin
                mul_a = 32'(f_reg);
                mul_b = ss_reg;
            end
            OP_MUL_P: begin
                mul_a = 32'(f_reg);
                mul_b = pss_reg;
            end
            OP_SQ: begin
                mul_a = 32'(quo_reg);
                mul_b = 32'(quo_reg);
            end
            OP_CUBE: begin
                mul_a = 32'(sq_reg);
                mul_b = 32'(quo_reg);
            end
            OP_THIRD: begin
                mul_a = 32'(cube_reg);
                mul_b = RECIP3;
            end
            OP_INTERP: begin
                mul_a = dmag_reg;
                mul_b = 32'(frac);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // Smoothed edge value, interpolation and rounding
    assign y    = quo_reg - third_reg;
    assign yval = neg_reg ? -$signed(32'(y)) : $signed(32'(y));
    assign diff = {f2_reg[31], f2_reg} - {f1_reg[31], f1_reg};
    assign q    = prod[PHASE_FRAC_BITS +: 31];
    assign v    = dneg_reg ? f1_reg - $signed({1'b0, q}) : f1_reg + $signed({1'b0, q});
    assign rv   = {v_reg[31], v_reg} + 33'sd16384;

    // Configuration, phase and pulse latch
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pss_reg   <= RST_PHASE_STEP_SCALE;
            pw_reg    <= RST_PULSE_WIDTH;
            bw_reg    <= RST_BANDWIDTH;
            ss_reg    <= RST_SLEW_SCALE;
            phase_reg <= '0;
            held_reg  <= CW'(RST_HELD_WIDTH);
            done_reg  <= 1'b1;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PHASE_STEP_SCALE: pss_reg <= cfg_data;
                    CFG_PULSE_WIDTH:      pw_reg  <= cfg_data[16:0];
                    CFG_BANDWIDTH:        bw_reg  <= cfg_data[23:0];
                    CFG_SLEW_SCALE:       ss_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == OP_LOAD && s_sync) begin
                phase_reg <= sp_ext[PW-1:0];
            end
            if (cmd.op == OP_ROUND) begin
                phase_reg <= phase_reg + step_reg;
            end
            if (cmd.op == OP_SETUP && !cmd.pt) begin
                if (rg == RG_RISE && done_reg) begin
                    held_reg <= held_latch;
                    done_reg <= 1'b0;
                end else if (rg == RG_FALL) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                f_reg <= (f_abs > bw_reg) ? bw_reg : f_abs;
            end
            OP_MUL_S: begin
                s_reg <= (prod[55:24] > 32'(TQ8)) ? TQ8_C : CW'(prod[55:24]);
            end
            OP_MUL_P: begin
                step_reg <= prod[36-PHASE_FRAC_BITS +: PW];
            end
            OP_SETUP: begin
                if (stat.konst) begin
                    if (cmd.pt) begin
                        f2_reg <= kval;
                    end else begin
                        f1_reg <= kval;
                    end
                end else begin
                    neg_reg <= neg_c;
                    quo_reg <= {30'd0, ge0};
                    rem_reg <= ge0 ? mag - s_reg : mag;
                end
            end
            OP_DIV: begin
                rem_reg <= r2[CW-1:0];
                quo_reg <= {quo_reg[28:0], g1, g2};
            end
            OP_SQ: begin
                sq_reg <= prod[60:30];
            end
            OP_CUBE: begin
                cube_reg <= prod[60:30];
            end
            OP_THIRD: begin
                third_reg <= prod[63:33];
            end
            OP_FIN: begin
                if (cmd.pt) begin
                    f2_reg <= yval;
                end else begin
                    f1_reg <= yval;
                end
            end
            OP_DIFF: begin
                dneg_reg <= diff[32];
                dmag_reg <= diff[32] ? 32'(-diff) : diff[31:0];
            end
            OP_INTERP: begin
                v_reg <= v;
            end
            OP_ROUND: begin
                sample_reg <= rv[30:15];
            end
            default: ;
        endcase
    end

    assign m_sample = sample_reg;

endmodule

FILE: rtl/core/spo_checker.sv
// Port-level checks of the smoothed pulse oscillator, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spo_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_sample
);
    // a stalled word keeps its value
    `ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_sample))
    // one word in flight: busy right after an accept
    `ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // no result appears the cycle after an accept while the output is empty
    `ASSERT_NXT(a_no_instant_result, aclk, aresetn, s_valid && s_ready && !m_valid, !m_valid)
    // output stays within two thirds of full scale
    `ASSERT_IMP(a_sample_range, aclk, aresetn, m_valid, (m_sample <= 16'sd21845) && (m_sample >= -16'sd21845))
endmodule

bind smoothed_pulse_oscillator spo_checker u_spo_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_sample (m_sample)
);

FILE: verif/smoothed_pulse_oscillator_test.sv
// Self-checking test of the smoothed pulse oscillator: directed and random words,
// sample word comparison against a built-in predictor. Depends on spo_pkg.
`timescale 1ns / 1ps
module smoothed_pulse_oscillator_test;
    import spo_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int HOLD_CYCLES    = 600;
    localparam longint unsigned TBL_Q8 = 512 << 8;
    localparam longint unsigned CYC    = 64'd512 << 23;
    localparam longint TWO3            = 715827883;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = CFG_PHASE_STEP_SCALE;
    logic [31:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [23:0] s_freq = '0;
    logic               s_sync = 1'b0;
    logic [31:0]        s_sync_phase = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_sample;

    smoothed_pulse_oscillator u_top (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predictor copy of the registers and the oscillator state
    longint unsigned step_scale_r, pw_r, bw_r, slew_r;
    longint unsigned osc_phase, osc_held;
    bit              osc_done;

    logic [15:0] sample_q[$];
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_off = 0;
    int          hold_req = 0;
    int          hold_ack = 0;
    int          quiet_cycles = 0;

    function automatic logic [1:0] region_of(longint unsigned p, longint unsigned s,
                                             longint unsigned h);
        if (p <= s) return RG_RISE;
        if (p < h) return RG_HIGH;
        if (p <= s + h) return RG_FALL;
        return RG_LOW;
    endfunction

    // x - x^3/3 in Q.30, x = +-mag/s
    function automatic longint shape_edge(longint unsigned mag, bit neg, longint unsigned s);
        longint unsigned m, cube, y;
        m = (mag << 30) / s;
        if (m > (64'd1 << 30)) m = 64'd1 << 30;
        cube = (((m * m) >> 30) * m) >> 30;
        y = m - cube / 3;
        return neg ? -longint'(y) : longint'(y);
    endfunction

    function automatic longint level_at(logic [1:0] rg, longint unsigned p,
                                        longint unsigned s, longint unsigned h);
        longint unsigned a;
        case (rg)
            RG_RISE: begin
                if (s == 0) return TWO3;
                a = 2 * p;
                if (a >= s) return shape_edge(a - s, 1'b0, s);
                return shape_edge(s - a, 1'b1, s);
            end
            RG_HIGH: return TWO3;
            RG_FALL: begin
                if (s == 0) return -TWO3;
                a = 2 * (p - h);
                if (s >= a) return shape_edge(s - a, 1'b0, s);
                return shape_edge(a - s, 1'b1, s);
            end
            default: return -TWO3;
        endcase
    endfunction

    // Work out the sample of one word and advance the oscillator state
    function automatic logic [15:0] next_sample(logic [23:0] fr, bit sy, logic [31:0] sp);
        longint unsigned raw, f, s, idx, frac, p0, p1, mag, q, w, stp;
        logic [1:0] r0, r1;
        longint f1, f2, diff, v;
        raw = fr;
        if (sy) osc_phase = longint'(sp) % CYC;
        f = raw[23] ? (64'h1000000 - raw) : raw;
        if (f > bw_r) f = bw_r;
        s = (f * slew_r) >> 24;
        if (s > TBL_Q8) s = TBL_Q8;
        idx = osc_phase >> 23;
        frac = osc_phase & ((64'd1 << 23) - 1);
        p0 = idx << 8;
        p1 = (idx + 1) << 8;
        r0 = region_of(p0, s, osc_held);
        if (r0 == RG_RISE && osc_done) begin
            if (pw_r < s) osc_held = s;
            else if (pw_r > TBL_Q8 - s) osc_held = TBL_Q8 - s;
            else osc_held = pw_r;
            osc_done = 1'b0;
        end else if (r0 == RG_FALL) begin
            osc_done = 1'b1;
        end
        f1 = level_at(r0, p0, s, osc_held);
        r1 = region_of(p1, s, osc_held);
        f2 = level_at(r1, p1, s, osc_held);
        diff = f2 - f1;
        mag = longint'(diff < 0 ? -diff : diff);
        q = (mag * frac) >> 23;
        v = diff < 0 ? f1 - longint'(q) : f1 + longint'(q);
        w = longint'(v + (64'sd1 << 31));
        w = (w + (64'd1 << 14)) >> 15;
        stp = ((f * step_scale_r) >> 13) % CYC;
        osc_phase = (osc_phase + stp) % CYC;
        return 16'(w - (64'd1 << 16));
    endfunction

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_ack != hold_req) begin
            hold_ack <= hold_req;
            hold_off <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            m_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each sample word with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (sample_q.size() == 0) begin
                $error("unexpected sample word %0d", m_sample);
                fail_count++;
            end else begin
                if (m_sample !== sample_q[0]) begin
                    $error("sample: expected %0d actual %0d",
                           $signed(sample_q[0]), m_sample);
                    fail_count++;
                end
                void'(sample_q.pop_front());
            end
        end
    end

    // Watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(logic [23:0] fr, bit sy, logic [31:0] sp);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_freq <= fr;
        s_sync <= sy;
        s_sync_phase <= sp;
        do @(posedge aclk); while (!s_ready);
        sample_q.push_back(next_sample(fr, sy, sp));
    endtask

    // Drop valid and wait until every sample has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (sample_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PHASE_STEP_SCALE: step_scale_r = data;
            CFG_PULSE_WIDTH:      pw_r = data & 32'h1FFFF;
            CFG_BANDWIDTH:        bw_r = data & 32'hFFFFFF;
            default:              slew_r = data;
        endcase
    endtask

    task automatic set_all(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
        drain();
        write_reg(CFG_PHASE_STEP_SCALE, a);
        write_reg(CFG_PULSE_WIDTH, b);
        write_reg(CFG_BANDWIDTH, c);
        write_reg(CFG_SLEW_SCALE, d);
    endtask

    function automatic logic [23:0] rand_freq();
        logic [23:0] f;
        if ($urandom_range(9) < 2) return 24'($urandom);
        f = 24'($urandom_range(0, 3000000));
        return $urandom_range(1) ? -f : f;
    endfunction

    // Field extremes, sync loads and the last table point at the defaults
    task automatic test_directed_defaults();
        send_word(24'd0, 1'b0, 32'd0);
        send_word(24'h7FFFFF, 1'b0, 32'd0);
        send_word(24'h800000, 1'b0, 32'd0);
        send_word(24'hFFFFFF, 1'b1, 32'hFFFFFFFF);
        send_word(24'd2560000, 1'b1, 32'd0);
        send_word(24'd256000, 1'b1, 32'h7FFFFFFF);
        send_word(24'd256000, 1'b1, 32'h80000000);
        send_word(-24'sd256000, 1'b0, 32'd0);
        send_word(24'd1, 1'b1, 32'hFF800000);
        send_word(24'd100000, 1'b0, 32'd0);
    endtask

    // Hard step, saturated ramp, pulse width and step extremes
    task automatic test_directed_extremes();
        set_all(32'd2863312, 32'd65536, 32'd2560000, 32'd0);
        send_word(24'd256000, 1'b1, 32'd0);
        send_word(24'd256000, 1'b1, 32'h80000000);
        send_word(24'd256000, 1'b1, 32'h80400000);
        set_all(32'hFFFFFFFF, 32'd1, 32'hFFFFFF, 32'hFFFFFFFF);
        send_word(24'h7FFFFF, 1'b1, 32'd0);
        send_word(24'h800000, 1'b0, 32'd0);
        send_word(24'd3, 1'b0, 32'd0);
        set_all(32'd0, 32'h1FFFF, 32'd1, 32'd429497);
        send_word(24'h7FFFFF, 1'b1, 32'h12345678);
        send_word(24'd0, 1'b0, 32'd0);
        set_all(32'd2863312, 32'hFFFFFFFF, 32'd2560000, 32'd4294967);
        send_word(24'd2560000, 1'b0, 32'd0);
        send_word(24'd1280000, 1'b1, 32'hFFFFFFFF);
    endtask

    // Random words in blocks, with a fresh random setting between blocks
    task automatic test_random(int blocks);
        for (int b = 0; b < blocks; b++) begin
            set_all($urandom_range(3) == 0 ? $urandom : $urandom_range(0, 30000000),
                    $urandom_range(3) == 0 ? $urandom : $urandom_range(1, 131071),
                    $urandom_range(3) == 0 ? $urandom : $urandom_range(1, 5000000),
                    $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 4000000));
            for (int i = 0; i < 50; i++)
                send_word(rand_freq(), $urandom_range(19) == 0, $urandom);
        end
    endtask

    // Long receiver hold-off while words keep arriving
    task automatic test_backpressure();
        drain();
        hold_req++;
        for (int i = 0; i < 20; i++)
            send_word(rand_freq(), 1'b0, 32'd0);
    endtask

    initial begin
        step_scale_r = 2863312;
        pw_r = 65536;
        bw_r = 2560000;
        slew_r = 429497;
        osc_phase = 0;
        osc_held = 65536;
        osc_done = 1'b1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 27;
        recv_idle_pct = 71;
        test_directed_defaults();
        test_directed_extremes();
        test_random(4);
        send_idle_pct = 71;
        recv_idle_pct = 27;
        test_random(4);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(4);
        test_backpressure();
        drain();

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
